### hdl/prlp_pkg.sv
// prlp_pkg: constants and pixel mask helper for the raster line packbits unit
// no dependencies; imported by pwg_raster_line_packbits_unit and the testbench

package prlp_pkg;

    // field widths
    localparam int PIX_W      = 48;
    localparam int HDR_W      = 8;
    localparam int CNT_W      = 2;
    localparam int PB_W       = 3;

    // literal buffer geometry
    localparam int LIT_DEPTH  = 128;
    localparam int LIT_AW     = $clog2(LIT_DEPTH);

    // run limits
    localparam logic [PB_W-1:0]   MAX_PIXEL_BYTES = 3'd6;
    localparam logic [PB_W-1:0]   PB_RESET        = 3'd3;
    localparam logic [LIT_AW-1:0] LIT_CUT         = 7'd127;
    localparam logic [7:0]        LIT_SPLIT       = 8'd126;
    localparam logic [7:0]        REP_MAX         = 8'd128;
    localparam logic [8:0]        LIT_HDR_BASE    = 9'd257;

    // byte mask for the active pixel width, zero acts as one byte, large values clamp to six bytes
    function automatic logic [PIX_W-1:0] chunk_mask(input logic [PB_W-1:0] nbytes);
        logic [PB_W-1:0]  eff;
        logic [PIX_W-1:0] m;
        eff = nbytes;
        if (nbytes == '0) begin
            eff = 3'd1;
        end else if (nbytes > MAX_PIXEL_BYTES) begin
            eff = MAX_PIXEL_BYTES;
        end
        m = '0;
        for (int i = 0; i < PIX_W / 8; i++) begin
            if (PB_W'(i) < eff) begin
                m[8*i +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

### hdl/pwg_raster_line_packbits_unit.sv
// pwg_raster_line_packbits_unit: packbits run-length encoder for one raster line
// depends on prlp_pkg (constants, pixel mask function)
//
//  channel  | handshake         | payload
//  ---------+-------------------+----------------------------------------------
//  input    | s_valid, s_ready  | s_pixel_value, s_line_end
//  result   | m_valid, m_ready  | m_has_header, m_header_byte, m_pixel_count,
//           |                   | m_first_pixel, m_second_pixel, m_record_last,
//           |                   | m_line_done
//  config   | cfg_we            | cfg_wdata (pixel_bytes)
//
// an input transfer is taken in ST_IDLE; an item that closes a record then
// passes through ST_REP per repeat result and through ST_LRD (memory read),
// then ST_LOUT (output load), per literal result, plus ST_FIX to move a cut
// pixel back to slot zero. one item is in work at a time; the literal buffer
// is read two pixels at a time into registers. a stalled result port holds the
// sequencer in place. reset is synchronous, active low; no clearing pass.

module pwg_raster_line_packbits_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [prlp_pkg::PB_W-1:0]   cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [prlp_pkg::PIX_W-1:0]  s_pixel_value,
    input  logic                        s_line_end,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_has_header,
    output logic [prlp_pkg::HDR_W-1:0]  m_header_byte,
    output logic [prlp_pkg::CNT_W-1:0]  m_pixel_count,
    output logic [prlp_pkg::PIX_W-1:0]  m_first_pixel,
    output logic [prlp_pkg::PIX_W-1:0]  m_second_pixel,
    output logic                        m_record_last,
    output logic                        m_line_done
);
    import prlp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REP,
        ST_LRD,
        ST_LOUT,
        ST_FIX
    } state_t;

    typedef enum logic [1:0] {
        REC_NONE,
        REC_REP,
        REC_LIT
    } rec_kind_t;

    // literal buffer
    logic [PIX_W-1:0]  lit_mem [0:LIT_DEPTH-1];
    logic              mem_we;
    logic [LIT_AW-1:0] mem_wa;
    logic [PIX_W-1:0]  mem_wd;
    logic              rd_en;
    logic [PIX_W-1:0]  rd_d0_reg, rd_d1_reg;

    // encoder state
    state_t            state_reg;
    logic [PB_W-1:0]   pb_reg;
    logic [LIT_AW-1:0] lc_reg, lc_next;
    logic [7:0]        rl_reg, rl_next;
    logic              rep_reg, rep_next;
    logic              pend_reg, pend_next;
    logic [PIX_W-1:0]  run_px_reg, run_px_next;
    logic [PIX_W-1:0]  last_lit_reg, last_lit_next;
    logic              fix_reg, fix_next;
    logic              end_reg;

    // record plan for the current item
    rec_kind_t         r0k_reg, r0k_next, r1k_reg, r1k_next;
    logic [7:0]        r0l_reg, r0l_next, r1l_reg, r1l_next;
    logic [7:0]        ptr_reg;

    // output register
    logic              m_valid_reg;
    logic              m_hh_reg;
    logic [HDR_W-1:0]  m_hdr_reg;
    logic [CNT_W-1:0]  m_cnt_reg;
    logic [PIX_W-1:0]  m_px0_reg, m_px1_reg;
    logic              m_last_reg, m_done_reg;

    logic              acc;
    logic              out_free;
    logic              out_load;
    logic [PIX_W-1:0]  x;
    logic              acc_we;
    logic [LIT_AW-1:0] acc_wa;
    logic              lit_two;
    logic              lit_tail;
    logic [7:0]        ptr_p1, ptr_p2;
    logic [HDR_W-1:0]  lit_hdr;

    assign s_ready  = (state_reg == ST_IDLE);
    assign acc      = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = ((state_reg == ST_REP) || (state_reg == ST_LOUT)) && out_free;
    assign x        = s_pixel_value & chunk_mask(pb_reg);

    // greedy parse of one incoming pixel
    always_comb begin
        lc_next       = lc_reg;
        rl_next       = rl_reg;
        rep_next      = rep_reg;
        pend_next     = pend_reg;
        run_px_next   = run_px_reg;
        last_lit_next = last_lit_reg;
        fix_next      = 1'b0;
        acc_we        = 1'b0;
        acc_wa        = '0;
        r0k_next      = REC_NONE;
        r0l_next      = '0;
        r1k_next      = REC_NONE;
        r1l_next      = '0;
        if (!pend_reg || (!rep_reg && lc_reg == '0)) begin
            // fresh segment
            acc_we        = 1'b1;
            last_lit_next = x;
            lc_next       = 7'd1;
            pend_next     = 1'b1;
            rep_next      = 1'b0;
            if (s_line_end) begin
                r0k_next = REC_LIT;
                r0l_next = 8'd1;
            end
        end else if (rep_reg) begin
            if (x == run_px_reg) begin
                // repeat run grows, sent at once when full
                if (rl_reg + 8'd1 >= REP_MAX) begin
                    r0k_next  = REC_REP;
                    r0l_next  = REP_MAX;
                    pend_next = 1'b0;
                    rep_next  = 1'b0;
                    rl_next   = '0;
                end else begin
                    rl_next = rl_reg + 8'd1;
                    if (s_line_end) begin
                        r0k_next = REC_REP;
                        r0l_next = rl_reg + 8'd1;
                    end
                end
            end else begin
                // repeat run closed, new literal starts with x
                r0k_next      = REC_REP;
                r0l_next      = rl_reg;
                acc_we        = 1'b1;
                last_lit_next = x;
                lc_next       = 7'd1;
                rep_next      = 1'b0;
                rl_next       = '0;
                if (s_line_end) begin
                    r1k_next = REC_LIT;
                    r1l_next = 8'd1;
                end
            end
        end else if (x == last_lit_reg) begin
            // equal pair ends the literal and opens a repeat run
            rep_next    = 1'b1;
            run_px_next = last_lit_reg;
            rl_next     = 8'd2;
            lc_next     = '0;
            if (lc_reg > 7'd1) begin
                r0k_next = REC_LIT;
                r0l_next = {1'b0, lc_reg} - 8'd1;
                if (s_line_end) begin
                    r1k_next = REC_REP;
                    r1l_next = 8'd2;
                end
            end else if (s_line_end) begin
                r0k_next = REC_REP;
                r0l_next = 8'd2;
            end
        end else if (lc_reg < LIT_CUT) begin
            last_lit_next = x;
            if (lc_reg + 7'd1 == LIT_CUT && !s_line_end) begin
                // literal cut: send the first part, x moves to slot zero after
                r0k_next = REC_LIT;
                r0l_next = LIT_SPLIT;
                lc_next  = 7'd1;
                fix_next = 1'b1;
            end else begin
                acc_we  = 1'b1;
                acc_wa  = lc_reg;
                lc_next = lc_reg + 7'd1;
                if (s_line_end) begin
                    r0k_next = REC_LIT;
                    r0l_next = {1'b0, lc_reg} + 8'd1;
                end
            end
        end
        // line end flushes whatever is pending
        if (s_line_end && pend_next) begin
            pend_next = 1'b0;
            rep_next  = 1'b0;
            lc_next   = '0;
            rl_next   = '0;
        end
    end

    // memory port control: reads only follow the writing cycle, so no overlap
    assign mem_we = (acc && acc_we) || (state_reg == ST_FIX);
    assign mem_wa = (state_reg == ST_FIX) ? '0 : acc_wa;
    assign mem_wd = (state_reg == ST_FIX) ? last_lit_reg : x;
    assign rd_en  = (state_reg == ST_LRD);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            lit_mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            rd_d0_reg <= lit_mem[ptr_reg[LIT_AW-1:0]];
            rd_d1_reg <= lit_mem[ptr_reg[LIT_AW-1:0] + 7'd1];
        end
    end

    // literal item helpers
    assign ptr_p1   = ptr_reg + 8'd1;
    assign ptr_p2   = ptr_reg + 8'd2;
    assign lit_two  = (ptr_p1 < r0l_reg);
    assign lit_tail = (ptr_p2 >= r0l_reg);
    assign lit_hdr  = HDR_W'(LIT_HDR_BASE - {1'b0, r0l_reg});

    // sequencer, encoder state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pb_reg       <= PB_RESET;
            lc_reg       <= '0;
            rl_reg       <= '0;
            rep_reg      <= 1'b0;
            pend_reg     <= 1'b0;
            run_px_reg   <= '0;
            last_lit_reg <= '0;
            fix_reg      <= 1'b0;
            end_reg      <= 1'b0;
            r0k_reg      <= REC_NONE;
            r1k_reg      <= REC_NONE;
            r0l_reg      <= '0;
            r1l_reg      <= '0;
            ptr_reg      <= '0;
            m_valid_reg  <= 1'b0;
            m_hh_reg     <= 1'b0;
            m_hdr_reg    <= '0;
            m_cnt_reg    <= '0;
            m_px0_reg    <= '0;
            m_px1_reg    <= '0;
            m_last_reg   <= 1'b0;
            m_done_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                pb_reg <= cfg_wdata;
            end
            if (m_ready && !out_load) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (acc) begin
                        lc_reg       <= lc_next;
                        rl_reg       <= rl_next;
                        rep_reg      <= rep_next;
                        pend_reg     <= pend_next;
                        run_px_reg   <= run_px_next;
                        last_lit_reg <= last_lit_next;
                        fix_reg      <= fix_next;
                        end_reg      <= s_line_end;
                        r0k_reg      <= r0k_next;
                        r0l_reg      <= r0l_next;
                        r1k_reg      <= r1k_next;
                        r1l_reg      <= r1l_next;
                        ptr_reg      <= '0;
                        if (r0k_next == REC_REP) begin
                            state_reg <= ST_REP;
                        end else if (r0k_next == REC_LIT) begin
                            state_reg <= ST_LRD;
                        end else if (fix_next) begin
                            state_reg <= ST_FIX;
                        end
                    end
                end
                ST_REP, ST_LOUT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        if (state_reg == ST_REP) begin
                            m_hh_reg  <= 1'b1;
                            m_hdr_reg <= {1'b0, 7'(r0l_reg - 8'd1)};
                            m_cnt_reg <= 2'd1;
                            m_px0_reg <= run_px_reg;
                            m_px1_reg <= '0;
                        end else begin
                            m_hh_reg  <= (ptr_reg == '0);
                            m_hdr_reg <= (ptr_reg == '0) ? lit_hdr : '0;
                            m_cnt_reg <= lit_two ? 2'd2 : 2'd1;
                            m_px0_reg <= rd_d0_reg;
                            m_px1_reg <= lit_two ? rd_d1_reg : '0;
                        end
                        if (state_reg == ST_REP || lit_tail) begin
                            // record complete: move on to the next one or finish
                            m_last_reg <= (r1k_reg == REC_NONE);
                            m_done_reg <= (r1k_reg == REC_NONE) && end_reg;
                            if (r1k_reg != REC_NONE) begin
                                r0k_reg   <= r1k_reg;
                                r0l_reg   <= r1l_reg;
                                r1k_reg   <= REC_NONE;
                                ptr_reg   <= '0;
                                state_reg <= (r1k_reg == REC_REP) ? ST_REP : ST_LRD;
                            end else begin
                                r0k_reg   <= REC_NONE;
                                state_reg <= fix_reg ? ST_FIX : ST_IDLE;
                            end
                        end else begin
                            m_last_reg <= 1'b0;
                            m_done_reg <= 1'b0;
                            ptr_reg    <= ptr_p2;
                            state_reg  <= ST_LRD;
                        end
                    end
                end
                ST_LRD: begin
                    state_reg <= ST_LOUT;
                end
                ST_FIX: begin
                    fix_reg   <= 1'b0;
                    state_reg <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // result port
    assign m_valid        = m_valid_reg;
    assign m_has_header   = m_hh_reg;
    assign m_header_byte  = m_hdr_reg;
    assign m_pixel_count  = m_cnt_reg;
    assign m_first_pixel  = m_px0_reg;
    assign m_second_pixel = m_px1_reg;
    assign m_record_last  = m_last_reg;
    assign m_line_done    = m_done_reg;

`ifndef SYNTHESIS
    // a pending literal segment always holds at least one pixel
    a_lit_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg && !rep_reg) |-> (lc_reg != '0))
        else $error("pending literal segment with zero pixels");

    // an open repeat run is between two and the maximum minus one
    a_run_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rep_reg |-> (pend_reg && rl_reg >= 8'd2 && rl_reg < REP_MAX))
        else $error("repeat run length out of range");

    // between items the literal never sits at the cut length
    a_lit_below_cut: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (lc_reg < LIT_CUT))
        else $error("literal count reached cut length while idle");

    // line done only comes with the last result of the item
    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_done_reg) |-> m_last_reg)
        else $error("line done without record last");
`endif

endmodule

### test/testbench.sv
// testbench: self-checking bench for pwg_raster_line_packbits_unit
// holds its own packbits line predictor in a scoreboard class and drives all three channels
// depends on prlp_pkg and the unit under test only

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import prlp_pkg::*;

    // one result transfer, in port order
    typedef struct packed {
        logic             has_header;
        logic [HDR_W-1:0] header_byte;
        logic [CNT_W-1:0] pixel_count;
        logic [PIX_W-1:0] first_pixel;
        logic [PIX_W-1:0] second_pixel;
        logic             record_last;
        logic             line_done;
    } rle_item_t;

    typedef enum logic [1:0] {SEG_REPEAT, SEG_LITERAL, SEG_NOISE} seg_kind_t;
    typedef enum logic [1:0] {
        LONG_NONE, LONG_REPEAT, LONG_LITERAL_END, LONG_LITERAL_CUT
    } long_seg_t;

    localparam int SETTLE_CYCLES = 16;
    localparam int STALL_LIMIT   = 3000;

    // line encoder predictor plus queue of records still owed by the unit
    class rle_scoreboard;
        rle_item_t        expected_records[$];
        logic [PIX_W-1:0] lit_buf[LIT_DEPTH];
        int               lit_count;
        logic [PIX_W-1:0] run_px;
        int               run_len;
        bit               repeating;
        bit               segment_open;
        logic [PB_W-1:0]  pix_bytes;
        int               errors;

        function new();
            lit_count    = 0;
            run_px       = '0;
            run_len      = 0;
            repeating    = 1'b0;
            segment_open = 1'b0;
            pix_bytes    = PB_RESET;
            errors       = 0;
        endfunction

        // active byte lanes, zero acts as one byte, large values clamp
        function logic [PIX_W-1:0] pixel_mask();
            int         eff;
            logic [63:0] m;
            eff = (pix_bytes == 0) ? 1 :
                  (pix_bytes > MAX_PIXEL_BYTES) ? int'(MAX_PIXEL_BYTES) : int'(pix_bytes);
            m = (64'd1 << (8 * eff)) - 64'd1;
            return m[PIX_W-1:0];
        endfunction

        function void push_record(logic hh, logic [HDR_W-1:0] hdr, logic [CNT_W-1:0] cnt,
                                  logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
            rle_item_t r;
            r.has_header   = hh;
            r.header_byte  = hh ? hdr : '0;
            r.pixel_count  = cnt;
            r.first_pixel  = a;
            r.second_pixel = (cnt == 2) ? b : '0;
            r.record_last  = 1'b0;
            r.line_done    = 1'b0;
            expected_records.push_back(r);
        endfunction

        // literal record: header on the first transfer, pixels two at a time
        function void push_literal(int n);
            int               k;
            bit               lead;
            logic [HDR_W-1:0] hdr;
            hdr  = HDR_W'(int'(LIT_HDR_BASE) - n);
            lead = 1'b1;
            for (k = 0; k < n; k += 2) begin
                if (k + 1 < n) begin
                    push_record(lead, hdr, 2'd2, lit_buf[k], lit_buf[k+1]);
                end else begin
                    push_record(lead, hdr, 2'd1, lit_buf[k], '0);
                end
                lead = 1'b0;
            end
        endfunction

        function void push_repeat();
            push_record(1'b1, HDR_W'((run_len - 1) & 127), 2'd1, run_px, '0);
        endfunction

        // greedy parse with one pixel of lookahead
        function void predict_records(logic [PIX_W-1:0] raw, logic le);
            logic [PIX_W-1:0] x;
            int               first;
            rle_item_t        tail;
            x     = raw & pixel_mask();
            first = expected_records.size();
            if (!segment_open || (!repeating && lit_count == 0)) begin
                lit_buf[0]   = x;
                lit_count    = 1;
                segment_open = 1'b1;
                repeating    = 1'b0;
            end else if (repeating) begin
                if (x == run_px) begin
                    run_len++;
                    // full repeat record goes out at once
                    if (run_len >= int'(REP_MAX)) begin
                        push_repeat();
                        segment_open = 1'b0;
                        repeating    = 1'b0;
                        run_len      = 0;
                    end
                end else begin
                    push_repeat();
                    lit_buf[0] = x;
                    lit_count  = 1;
                    repeating  = 1'b0;
                    run_len    = 0;
                end
            end else if (x == lit_buf[lit_count-1]) begin
                // equal pair closes the literal and opens a repeat
                if (lit_count > 1) push_literal(lit_count - 1);
                repeating = 1'b1;
                run_px    = lit_buf[lit_count-1];
                run_len   = 2;
                lit_count = 0;
            end else if (lit_count < int'(LIT_CUT)) begin
                lit_buf[lit_count] = x;
                lit_count++;
                // cut long literal, carry the newest pixel over
                if (lit_count >= int'(LIT_CUT) && !le) begin
                    push_literal(int'(LIT_CUT) - 1);
                    lit_buf[0] = lit_buf[int'(LIT_CUT)-1];
                    lit_count  = 1;
                end
            end

            // line end flushes whatever is pending
            if (le && segment_open) begin
                if (repeating) push_repeat();
                else push_literal(lit_count);
                segment_open = 1'b0;
                repeating    = 1'b0;
                lit_count    = 0;
                run_len      = 0;
            end

            if (expected_records.size() > first) begin
                tail             = expected_records.pop_back();
                tail.record_last = 1'b1;
                tail.line_done   = le;
                expected_records.push_back(tail);
            end
        endfunction

        function void report(string what, logic [PIX_W-1:0] want, logic [PIX_W-1:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
            end
        endfunction

        function void check_record(rle_item_t got);
            rle_item_t want;
            if (expected_records.size() == 0) begin
                errors++;
                $display("%0t: unexpected record, expected none actual %0h", $time, got);
                return;
            end
            want = expected_records.pop_front();
            report("has_header", want.has_header, got.has_header);
            report("header_byte", want.header_byte, got.header_byte);
            report("pixel_count", want.pixel_count, got.pixel_count);
            report("first_pixel", want.first_pixel, got.first_pixel);
            report("second_pixel", want.second_pixel, got.second_pixel);
            report("record_last", want.record_last, got.record_last);
            report("line_done", want.line_done, got.line_done);
        endfunction
    endclass

    logic              aclk;
    logic              aresetn        = 1'b0;
    logic              cfg_we         = 1'b0;
    logic [PB_W-1:0]   cfg_wdata      = '0;
    logic              s_valid        = 1'b0;
    logic              s_ready;
    logic [PIX_W-1:0]  s_pixel_value  = '0;
    logic              s_line_end     = 1'b0;
    logic              m_valid;
    logic              m_ready        = 1'b0;
    logic              m_has_header;
    logic [HDR_W-1:0]  m_header_byte;
    logic [CNT_W-1:0]  m_pixel_count;
    logic [PIX_W-1:0]  m_first_pixel;
    logic [PIX_W-1:0]  m_second_pixel;
    logic              m_record_last;
    logic              m_line_done;

    rle_scoreboard     sb;
    int                send_idle_pct  = 27;
    int                recv_idle_pct  = 76;
    int                items_sent     = 0;
    bit                line_open      = 1'b0;
    logic [PIX_W-1:0]  last_value     = '0;

    pwg_raster_line_packbits_unit u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pixel_value  (s_pixel_value),
        .s_line_end     (s_line_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_has_header   (m_has_header),
        .m_header_byte  (m_header_byte),
        .m_pixel_count  (m_pixel_count),
        .m_first_pixel  (m_first_pixel),
        .m_second_pixel (m_second_pixel),
        .m_record_last  (m_record_last),
        .m_line_done    (m_line_done)
    );

    // 50 MHz clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic logic [PIX_W-1:0] rand48();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[PIX_W-1:0];
    endfunction

    function automatic logic [PIX_W-1:0] fresh_value(logic [PIX_W-1:0] prev,
                                                     logic [PIX_W-1:0] mask);
        logic [PIX_W-1:0] v;
        do begin
            v = rand48() & mask;
        end while (v == prev);
        return v;
    endfunction

    // sometimes set junk above the active lanes
    function automatic logic [PIX_W-1:0] dress(logic [PIX_W-1:0] v, logic [PIX_W-1:0] mask);
        if ($urandom_range(0, 3) == 0) return v | (rand48() & ~mask);
        return v;
    endfunction

    // one input transfer with optional leading idle cycles
    task automatic send_pixel(input logic [PIX_W-1:0] px, input logic le);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_pixel_value <= px;
        s_line_end    <= le;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.predict_records(px, le);
        items_sent++;
        line_open = !le;
    endtask

    // hold input off until every owed record has come, then let the unit settle
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.expected_records.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_width(input logic [PB_W-1:0] width);
        cfg_wdata <= width;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sb.pix_bytes = width;
    endtask

    // run of equal pixels, adjacent-distinct literal, or random noise
    task automatic put_segment(input seg_kind_t kind, input int len, input logic closes);
        logic [PIX_W-1:0] mask;
        logic [PIX_W-1:0] v;
        logic             le;
        mask = sb.pixel_mask();
        v    = fresh_value(last_value, mask);
        for (int i = 0; i < len; i++) begin
            le = closes && (i == len - 1);
            if (kind == SEG_LITERAL && i > 0) v = fresh_value(v, mask);
            if (kind == SEG_NOISE) begin
                v  = $urandom_range(0, 1) ? rand48() : PIX_W'($urandom_range(0, 2));
                le = le || ($urandom_range(0, 5) == 0);
            end
            send_pixel(dress(v, mask), le);
        end
        last_value = v & mask;
    endtask

    task automatic run_phase(input int snd_pct, input int rcv_pct, input logic [PB_W-1:0] width,
                             input long_seg_t long_kind, input int target);
        int start;
        int segs_left;
        int roll;
        drain();
        write_width(width);
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        start = items_sent;
        // boundary segment first
        case (long_kind)
            LONG_REPEAT: begin
                put_segment(SEG_REPEAT, $urandom_range(128, 130), 1'b0);
            end
            LONG_LITERAL_END: begin
                if (line_open) put_segment(SEG_LITERAL, 1, 1'b1);
                put_segment(SEG_LITERAL, 127, 1'b1);
            end
            LONG_LITERAL_CUT: begin
                put_segment(SEG_LITERAL, $urandom_range(128, 131), 1'b0);
            end
            default: ;
        endcase
        // lines of short segments; a phase may stop mid-line
        segs_left = 0;
        while (items_sent - start < target) begin
            if (segs_left == 0) segs_left = $urandom_range(1, 5);
            segs_left--;
            roll = $urandom_range(0, 99);
            if (roll < 40) put_segment(SEG_REPEAT, $urandom_range(2, 9), segs_left == 0);
            else if (roll < 82) put_segment(SEG_LITERAL, $urandom_range(1, 10), segs_left == 0);
            else put_segment(SEG_NOISE, $urandom_range(1, 6), segs_left == 0);
        end
    endtask

    // result side: check each transfer, random back-pressure
    always @(posedge aclk) begin : result_monitor
        rle_item_t seen;
        seen = {m_has_header, m_header_byte, m_pixel_count, m_first_pixel,
                m_second_pixel, m_record_last, m_line_done};
        if (aresetn && m_valid && m_ready) sb.check_record(seen);
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // ends the run when no transfer happens for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_we) quiet = 0;
            else quiet++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        sb = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single pixel lines, zero and all ones with junk above the lanes
        send_pixel(48'h0, 1'b1);
        send_pixel(48'hFFFF_FFFF_FFFF, 1'b1);
        // equal in the active lanes, different above
        send_pixel(48'h11_123456, 1'b0);
        send_pixel(48'h22_123456, 1'b1);
        // literal then repeat
        send_pixel(48'h1, 1'b0);
        send_pixel(48'h2, 1'b0);
        send_pixel(48'h3, 1'b0);
        send_pixel(48'h3, 1'b0);
        send_pixel(48'h3, 1'b1);
        // repeat then odd literal
        send_pixel(48'h5, 1'b0);
        send_pixel(48'h5, 1'b0);
        send_pixel(48'h6, 1'b0);
        send_pixel(48'h7, 1'b0);
        send_pixel(48'h8, 1'b1);
        // width change in the middle of a line
        send_pixel(48'h9, 1'b0);
        send_pixel(48'hA, 1'b0);
        drain();
        write_width(3'd6);
        send_pixel(48'h12_0000_000A, 1'b0);
        send_pixel(48'h12_0000_000A, 1'b1);
        send_pixel(48'hFFFF_FFFF_FFFF, 1'b0);
        send_pixel(48'hFFFF_FFFF_FFFF, 1'b1);

        // random lines across widths and idle patterns
        run_phase(27, 76, 3'd6, LONG_NONE, 12);
        run_phase(27, 76, 3'd1, LONG_REPEAT, 12);
        run_phase(76, 27, 3'd0, LONG_LITERAL_END, 12);
        run_phase(76, 27, 3'd7, LONG_NONE, 12);
        run_phase(0, 0, 3'd2, LONG_LITERAL_CUT, 12);
        run_phase(0, 0, PB_W'($urandom_range(1, 6)), LONG_NONE, 12);
        drain();

        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
